[sv/pwl_pkg.sv]
package pwl_pkg;

    localparam int ADC_W  = 12;
    localparam int DUTY_W = 7;
    localparam int ROW_W  = 6;
    localparam int NUM_W  = ADC_W + DUTY_W;
    localparam int DEN_W  = ADC_W;

    localparam logic [DUTY_W-1:0] DUTY_MAX = DUTY_W'(100);

    typedef struct packed {
        logic [ADC_W-1:0]  x;
        logic [DUTY_W-1:0] y;
    } t_bp;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] dividend;
        logic [DEN_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [NUM_W-1:0] quotient;
    } t_div_rsp;

    // breakpoint rom, rows past the given points read as zero
    function automatic t_bp bp_row(logic [ROW_W-1:0] idx);
        t_bp r;
        unique case (idx)
            ROW_W'(0):  r = '{x: ADC_W'(1023), y: DUTY_W'(0)};
            ROW_W'(1):  r = '{x: ADC_W'(1086), y: DUTY_W'(9)};
            ROW_W'(2):  r = '{x: ADC_W'(1506), y: DUTY_W'(18)};
            ROW_W'(3):  r = '{x: ADC_W'(1842), y: DUTY_W'(27)};
            ROW_W'(4):  r = '{x: ADC_W'(1989), y: DUTY_W'(36)};
            ROW_W'(5):  r = '{x: ADC_W'(2073), y: DUTY_W'(45)};
            ROW_W'(6):  r = '{x: ADC_W'(2115), y: DUTY_W'(55)};
            ROW_W'(7):  r = '{x: ADC_W'(2178), y: DUTY_W'(64)};
            ROW_W'(8):  r = '{x: ADC_W'(2241), y: DUTY_W'(73)};
            ROW_W'(9):  r = '{x: ADC_W'(2367), y: DUTY_W'(82)};
            ROW_W'(10): r = '{x: ADC_W'(2682), y: DUTY_W'(91)};
            ROW_W'(11): r = '{x: ADC_W'(3123), y: DUTY_W'(100)};
            default:    r = '{x: '0, y: '0};
        endcase
        return r;
    endfunction

endpackage

[sv/pwl_if.sv]
interface pwl_in_if;
    logic        valid;
    logic        ready;
    logic [11:0] adc_sample;

    modport source(output valid, output adc_sample, input ready);
    modport sink(input valid, input adc_sample, output ready);
endinterface

interface pwl_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] duty_level;
    logic       clamped;

    modport source(output valid, output duty_level, output clamped, input ready);
    modport sink(input valid, input duty_level, input clamped, output ready);
endinterface

[sv/pwl_div.sv]
module pwl_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pwl_pkg::t_div_req i_req,
    output pwl_pkg::t_div_rsp o_rsp
);
    import pwl_pkg::*;

    localparam int CNT_W = $clog2(NUM_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W-1:0] r_rem;
    logic [NUM_W-1:0] r_quo;

    logic [DEN_W:0]   w_trial;
    logic             w_ge;
    logic [DEN_W-1:0] w_rem;

    // one restoring step per cycle, msb first
    assign w_trial = {r_rem, r_quo[NUM_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_den};
    assign w_rem   = w_ge ? DEN_W'(w_trial - {1'b0, r_den}) : w_trial[DEN_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= !i_req.start && r_busy && (r_cnt == CNT_W'(NUM_W - 1));
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_den  <= i_req.divisor;
                r_rem  <= '0;
                r_quo  <= i_req.dividend;
            end else if (r_busy) begin
                r_rem <= w_rem;
                r_quo <= {r_quo[NUM_W-2:0], w_ge};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(NUM_W - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy) && !r_busy)
        else $error("divider done without a running division");
    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && r_den != '0 |-> r_rem < r_den)
        else $error("partial remainder not below divisor");
    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !i_req.start)
        else $error("divider restarted while busy");

endmodule

[sv/piecewise_linear_adc_to_duty_top.sv]
// Maps one 12-bit paddle sample per request to a duty level 0..100 through a
// rom of NUM_POINTS breakpoints. A sample at or below the first breakpoint gives
// 0, one above the last gives 100, both with clamped set; otherwise the segment is
// found by a serial scan and interpolated with one multiply and one restoring
// divider, its quotient truncated. The block takes one request at a time: a
// clamped sample goes from the range check straight to the output step, an
// interpolated one also scans k breakpoints (1 to NUM_POINTS-1) and runs the
// bit-serial divide. The result register lets the next request enter while a
// result still waits.
module piecewise_linear_adc_to_duty_top #(
    parameter int NUM_POINTS = 12
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    pwl_in_if.sink    i_req,
    pwl_out_if.source o_res
);
    import pwl_pkg::*;

    localparam int IW = (NUM_POINTS > 2) ? $clog2(NUM_POINTS) : 1;
    localparam logic [IW-1:0] LAST = IW'(NUM_POINTS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SEARCH,
        S_MUL,
        S_DIVGO,
        S_DIV,
        S_OUT
    } t_state;

    t_state            r_state;
    logic [ADC_W-1:0]  r_a;
    logic [IW-1:0]     r_idx;
    logic [ADC_W-1:0]  r_x1;
    logic [ADC_W-1:0]  r_x2;
    logic [DUTY_W-1:0] r_y1;
    logic [DUTY_W-1:0] r_y2;
    logic              r_fall;
    logic [NUM_W-1:0]  r_prod;
    logic [DEN_W-1:0]  r_dx;
    logic [DUTY_W-1:0] r_duty;
    logic              r_clamp;
    logic              r_out_valid;
    logic [DUTY_W-1:0] r_res_duty;
    logic              r_res_clamp;

    t_bp               w_first;
    t_bp               w_last;
    t_bp               w_cur;
    t_bp               w_prev;
    logic [ADC_W-1:0]  w_da;
    logic [DUTY_W-1:0] w_dy;
    t_div_req          w_div_req;
    t_div_rsp          w_div_rsp;
    logic              w_out_free;

    assign w_first = bp_row('0);
    assign w_last  = bp_row(ROW_W'(LAST));
    assign w_cur   = bp_row(ROW_W'(r_idx));
    assign w_prev  = bp_row(ROW_W'(r_idx - 1'b1));

    assign w_da = (r_a > r_x1) ? ADC_W'(r_a - r_x1) : '0;
    assign w_dy = r_fall ? DUTY_W'(r_y1 - r_y2) : DUTY_W'(r_y2 - r_y1);

    assign w_div_req.start    = (r_state == S_DIVGO);
    assign w_div_req.dividend = r_prod;
    assign w_div_req.divisor  = r_dx;

    pwl_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_div_req),
        .o_rsp  (w_div_rsp)
    );

    assign w_out_free  = !r_out_valid || o_res.ready;
    assign i_req.ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && o_res.ready && r_state != S_OUT) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_a     <= i_req.adc_sample;
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    priority if (r_a <= w_first.x) begin
                        r_duty  <= '0;
                        r_clamp <= 1'b1;
                        r_state <= S_OUT;
                    end else if (r_a > w_last.x) begin
                        r_duty  <= DUTY_MAX;
                        r_clamp <= 1'b1;
                        r_state <= S_OUT;
                    end else begin
                        r_idx   <= IW'(1);
                        r_state <= S_SEARCH;
                    end
                end
                S_SEARCH: begin
                    if (w_cur.x >= r_a || r_idx == LAST) begin
                        r_x1    <= w_prev.x;
                        r_y1    <= w_prev.y;
                        r_x2    <= w_cur.x;
                        r_y2    <= w_cur.y;
                        r_fall  <= w_cur.y < w_prev.y;
                        r_state <= S_MUL;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_MUL: begin
                    r_clamp <= 1'b0;
                    if (r_x2 <= r_x1) begin
                        r_duty  <= r_y2;
                        r_state <= S_OUT;
                    end else begin
                        r_prod  <= NUM_W'(w_da) * NUM_W'(w_dy);
                        r_dx    <= DEN_W'(r_x2 - r_x1);
                        r_state <= S_DIVGO;
                    end
                end
                S_DIVGO: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (w_div_rsp.done) begin
                        if (!r_fall) begin
                            r_duty <= DUTY_W'(r_y1 + w_div_rsp.quotient[DUTY_W-1:0]);
                        end else if (w_div_rsp.quotient >= NUM_W'(r_y1)) begin
                            r_duty <= '0;
                        end else begin
                            r_duty <= DUTY_W'(r_y1 - w_div_rsp.quotient[DUTY_W-1:0]);
                        end
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_res_duty  <= r_duty;
                        r_res_clamp <= r_clamp;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.duty_level = r_res_duty;
    assign o_res.clamped    = r_res_clamp;

    a_clamp_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.clamped |->
            o_res.duty_level == '0 || o_res.duty_level == DUTY_MAX)
        else $error("clamped result not at an end of the range");
    a_duty_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> o_res.duty_level <= DUTY_MAX)
        else $error("duty level above full scale");
    a_search_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SEARCH |-> r_a > w_first.x && r_a <= w_last.x)
        else $error("segment scan on a sample outside the table");
    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_rsp.done |-> r_state == S_DIV)
        else $error("divider finished outside the divide step");

endmodule

[tb/tb_piecewise_linear_adc_to_duty_top.sv]
`timescale 1ns / 1ps

module tb_piecewise_linear_adc_to_duty_top;
    import pwl_pkg::*;

    localparam int NUM_POINTS = 12;
    localparam int N_DIR      = 24;
    localparam int N_RAND     = 1550;
    localparam int TAIL_CYC   = 64;
    localparam int HOLD_AT    = 300;
    localparam int HOLD_CYC   = 600;

    localparam logic [ADC_W-1:0] BP_X [NUM_POINTS] = '{
        12'd1023, 12'd1086, 12'd1506, 12'd1842, 12'd1989, 12'd2073,
        12'd2115, 12'd2178, 12'd2241, 12'd2367, 12'd2682, 12'd3123
    };
    localparam logic [DUTY_W-1:0] BP_Y [NUM_POINTS] = '{
        7'd0, 7'd9, 7'd18, 7'd27, 7'd36, 7'd45,
        7'd55, 7'd64, 7'd73, 7'd82, 7'd91, 7'd100
    };

    typedef struct packed {
        logic [DUTY_W-1:0] duty;
        logic              clamped;
    } t_duty_res;

    typedef struct packed {
        logic [ADC_W-1:0]  adc;
        logic              known;
        logic [DUTY_W-1:0] duty;
        logic              clamped;
    } t_dir_row;

    logic i_clk;
    logic i_rst_n;

    pwl_in_if  req ();
    pwl_out_if res ();

    t_duty_res duty_exp_q [$];
    t_dir_row  dir_rows [N_DIR];
    int        n_errors;
    int        n_results;
    bit        calm;

    piecewise_linear_adc_to_duty_top #(
        .NUM_POINTS(NUM_POINTS)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req.sink),
        .o_res  (res.source)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_duty_res predict_duty(logic [ADC_W-1:0] a);
        t_duty_res r;
        int seg;
        int x1, y1, x2, y2, da, q, v;
        r.clamped = 1'b0;
        if (a <= BP_X[0]) begin
            r.duty    = '0;
            r.clamped = 1'b1;
        end else if (a > BP_X[NUM_POINTS-1]) begin
            r.duty    = DUTY_MAX;
            r.clamped = 1'b1;
        end else begin
            seg = NUM_POINTS - 1;
            for (int i = NUM_POINTS - 1; i >= 1; i--) begin
                if (BP_X[i] >= a) seg = i;
            end
            x1 = BP_X[seg-1];
            y1 = BP_Y[seg-1];
            x2 = BP_X[seg];
            y2 = BP_Y[seg];
            da = (int'(a) > x1) ? int'(a) - x1 : 0;
            if (x2 <= x1) begin
                v = y2;
            end else if (y2 >= y1) begin
                v = y1 + (da * (y2 - y1)) / (x2 - x1);
            end else begin
                q = (da * (y1 - y2)) / (x2 - x1);
                v = (q >= y1) ? 0 : y1 - q;
            end
            r.duty = DUTY_W'(v);
        end
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 80);
    endfunction

    function automatic logic [ADC_W-1:0] pick_sample();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return ADC_W'($urandom_range(int'(BP_X[0]) + 1, int'(BP_X[NUM_POINTS-1])));
        if (r < 75) return BP_X[$urandom_range(0, NUM_POINTS-1)] + ADC_W'($urandom_range(0, 4))
                           - ADC_W'(2);
        return ADC_W'($urandom);
    endfunction

    task automatic send_sample(logic [ADC_W-1:0] s, t_duty_res exp_res);
        int gap;
        gap = calm ? 0 : pick_gap();
        if (gap > 0) begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req.valid      <= 1'b1;
        req.adc_sample <= s;
        do @(posedge i_clk); while (!req.ready);
        duty_exp_q.push_back(exp_res);
    endtask

    initial begin
        #12ms;
        $display("piecewise_linear_adc_to_duty_top test failed");
        $finish;
    end

    // result side: random stalls plus one long hold-off
    initial begin : result_sink
        int        stall_left;
        bit        hold_done;
        t_duty_res e;
        stall_left = 0;
        hold_done  = 1'b0;
        res.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && res.valid && res.ready) begin
                n_results++;
                if (duty_exp_q.size() == 0) begin
                    $error("unexpected result duty_level=%0d clamped=%0b",
                           res.duty_level, res.clamped);
                    n_errors++;
                end else begin
                    e = duty_exp_q.pop_front();
                    if (res.duty_level !== e.duty) begin
                        $error("duty_level expected %0d actual %0d", e.duty, res.duty_level);
                        n_errors++;
                    end
                    if (res.clamped !== e.clamped) begin
                        $error("clamped expected %0b actual %0b", e.clamped, res.clamped);
                        n_errors++;
                    end
                end
            end
            if (!i_rst_n) begin
                res.ready <= 1'b0;
            end else if (!hold_done && n_results >= HOLD_AT) begin
                hold_done  = 1'b1;
                stall_left = HOLD_CYC;
                res.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                res.ready <= 1'b0;
            end else if (calm) begin
                res.ready <= 1'b1;
            end else begin
                stall_left = pick_gap();
                res.ready <= 1'b1;
            end
        end
    end

    initial begin
        t_duty_res e;
        logic [ADC_W-1:0] s;
        i_clk          = 1'b0;
        n_errors       = 0;
        n_results      = 0;
        calm           = 1'b0;
        i_rst_n       <= 1'b0;
        req.valid     <= 1'b0;
        req.adc_sample <= '0;

        dir_rows[0]  = '{12'd0,    1'b1, 7'd0,   1'b1};
        dir_rows[1]  = '{12'd4095, 1'b1, 7'd100, 1'b1};
        dir_rows[2]  = '{12'd1022, 1'b1, 7'd0,   1'b1};
        dir_rows[3]  = '{12'd1023, 1'b1, 7'd0,   1'b1};
        dir_rows[4]  = '{12'd1024, 1'b0, 7'd0,   1'b0};
        dir_rows[5]  = '{12'd1086, 1'b1, 7'd9,   1'b0};
        dir_rows[6]  = '{12'd1087, 1'b0, 7'd0,   1'b0};
        dir_rows[7]  = '{12'd1505, 1'b0, 7'd0,   1'b0};
        dir_rows[8]  = '{12'd1506, 1'b1, 7'd18,  1'b0};
        dir_rows[9]  = '{12'd1842, 1'b1, 7'd27,  1'b0};
        dir_rows[10] = '{12'd1989, 1'b1, 7'd36,  1'b0};
        dir_rows[11] = '{12'd2073, 1'b1, 7'd45,  1'b0};
        dir_rows[12] = '{12'd2115, 1'b1, 7'd55,  1'b0};
        dir_rows[13] = '{12'd2178, 1'b1, 7'd64,  1'b0};
        dir_rows[14] = '{12'd2241, 1'b1, 7'd73,  1'b0};
        dir_rows[15] = '{12'd2367, 1'b1, 7'd82,  1'b0};
        dir_rows[16] = '{12'd2682, 1'b1, 7'd91,  1'b0};
        dir_rows[17] = '{12'd3122, 1'b0, 7'd0,   1'b0};
        dir_rows[18] = '{12'd3123, 1'b1, 7'd100, 1'b0};
        dir_rows[19] = '{12'd3124, 1'b1, 7'd100, 1'b1};
        dir_rows[20] = '{12'd2048, 1'b0, 7'd0,   1'b0};
        dir_rows[21] = '{12'haaa,  1'b0, 7'd0,   1'b0};
        dir_rows[22] = '{12'h555,  1'b0, 7'd0,   1'b0};
        dir_rows[23] = '{12'd2500, 1'b0, 7'd0,   1'b0};

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[k]) begin
            if (dir_rows[k].known)
                e = '{duty: dir_rows[k].duty, clamped: dir_rows[k].clamped};
            else
                e = predict_duty(dir_rows[k].adc);
            send_sample(dir_rows[k].adc, e);
        end

        for (int n = 0; n < N_RAND; n++) begin
            calm = (n >= 700 && n < 900);
            s = pick_sample();
            send_sample(s, predict_duty(s));
        end
        calm = 1'b0;
        req.valid <= 1'b0;

        while (duty_exp_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYC) @(posedge i_clk);

        if (n_errors == 0)
            $display("piecewise_linear_adc_to_duty_top test passed");
        else
            $display("piecewise_linear_adc_to_duty_top test failed");
        $finish;
    end

endmodule
